// ----- hdl/lnsm_pkg.sv -----
package lnsm_pkg;

    localparam int DIM_W  = 13;
    localparam int PIX_W  = 12;
    localparam int BPP_W  = 3;
    localparam int OFS_W  = 26;
    localparam int PROD_W = 2 * DIM_W;

    localparam int MAX_DIMENSION_DEF = 4096;

    localparam int IN_TDATA_W  = 2 * PIX_W;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BPP   = 3'd4;

    localparam logic [BPP_W-1:0] BPP_RGB  = 3'd3;
    localparam logic [BPP_W-1:0] BPP_RGBA = 3'd4;

    // drawn rectangle, valid while the solver is done
    typedef struct packed {
        logic             err;
        logic [DIM_W-1:0] dw;
        logic [DIM_W-1:0] dh;
        logic [DIM_W-1:0] x0;
        logic [DIM_W-1:0] y0;
    } geom_t;

    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic             qbit;
    } div_step_t;

    // one restoring division step; rem < dvs keeps the new rem in DIM_W bits
    function automatic div_step_t div_step(input logic [DIM_W-1:0] rem,
                                           input logic             din,
                                           input logic [DIM_W-1:0] dvs);
        logic [DIM_W:0] t;
        logic [DIM_W:0] diff;
        div_step_t      r;
        t    = {rem, din};
        diff = t - {1'b0, dvs};
        if (t >= {1'b0, dvs})
        begin
            r.rem  = diff[DIM_W-1:0];
            r.qbit = 1'b1;
        end
        else
        begin
            r.rem  = t[DIM_W-1:0];
            r.qbit = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hdl/lnsm_geom.sv -----
module lnsm_geom #(
    parameter int MAX_DIMENSION = lnsm_pkg::MAX_DIMENSION_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         restart,
    input  logic [lnsm_pkg::DIM_W-1:0]   sw,
    input  logic [lnsm_pkg::DIM_W-1:0]   sh,
    input  logic [lnsm_pkg::DIM_W-1:0]   tw,
    input  logic [lnsm_pkg::DIM_W-1:0]   th,
    input  logic [lnsm_pkg::BPP_W-1:0]   bpp,
    output lnsm_pkg::geom_t              geom,
    output logic                         rdy
);
    import lnsm_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [4:0] {
        G_START  = 5'b00001,
        G_DIVH   = 5'b00010,
        G_DIVW   = 5'b00100,
        G_FINISH = 5'b01000,
        G_DONE   = 5'b10000
    } gstate_t;

    gstate_t            state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [PROD_W-1:0]  dvd_reg, dvd_next;
    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [DIM_W-1:0]   rem_reg, rem_next;
    logic [DIM_W-1:0]   dvs_reg, dvs_next;
    logic [DIM_W-1:0]   dw_reg, dw_next;
    logic [DIM_W-1:0]   dh_reg, dh_next;
    geom_t              geom_reg, geom_next;

    div_step_t          st;
    logic [PROD_W-1:0]  q_fin;
    logic               last;
    logic [DIM_W-1:0]   x_slack;
    logic [DIM_W-1:0]   y_slack;

    function automatic logic dim_ok(input logic [DIM_W-1:0] d);
        return (d != '0) && (32'(d) <= MAX_DIMENSION);
    endfunction

    assign st      = div_step(rem_reg, dvd_reg[PROD_W-1], dvs_reg);
    assign q_fin   = {quo_reg[PROD_W-2:0], st.qbit};
    assign last    = (cnt_reg == CNT_W'(PROD_W - 1));
    assign x_slack = tw - dw_reg;
    assign y_slack = th - dh_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        dw_next    = dw_reg;
        dh_next    = dh_reg;
        geom_next  = geom_reg;
        unique case (state_reg)
            G_START:
            begin
                dvd_next   = {{DIM_W{1'b0}}, tw} * {{DIM_W{1'b0}}, sh};
                dvs_next   = sw;
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = G_DIVH;
            end
            G_DIVH, G_DIVW:
            begin
                rem_next = st.rem;
                quo_next = q_fin;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (last)
                begin
                    if (state_reg == G_DIVW)
                    begin
                        dw_next    = q_fin[DIM_W-1:0];
                        state_next = G_FINISH;
                    end
                    else if (q_fin > {{DIM_W{1'b0}}, th})
                    begin
                        // too tall at full width: fit the height instead
                        dh_next    = th;
                        dvd_next   = {{DIM_W{1'b0}}, th} * {{DIM_W{1'b0}}, sw};
                        dvs_next   = sh;
                        rem_next   = '0;
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = G_DIVW;
                    end
                    else
                    begin
                        dw_next    = tw;
                        dh_next    = q_fin[DIM_W-1:0];
                        state_next = G_FINISH;
                    end
                end
            end
            G_FINISH:
            begin
                geom_next.err = !dim_ok(tw) || !dim_ok(th) || !dim_ok(sw) || !dim_ok(sh)
                                || (bpp != BPP_RGB && bpp != BPP_RGBA)
                                || (dw_reg == '0) || (dh_reg == '0);
                geom_next.dw  = dw_reg;
                geom_next.dh  = dh_reg;
                geom_next.x0  = x_slack >> 1;
                geom_next.y0  = y_slack >> 1;
                state_next    = G_DONE;
            end
            G_DONE:
            begin
                state_next = G_DONE;
            end
            default:
            begin
                state_next = G_START;
            end
        endcase
        if (restart)
        begin
            state_next = G_START;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= G_START;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        dw_reg   <= dw_next;
        dh_reg   <= dh_next;
        geom_reg <= geom_next;
    end

    assign geom = geom_reg;
    assign rdy  = (state_reg == G_DONE) && !restart;

endmodule

// ----- hdl/letterbox_nearest_scaler_map.sv -----
// Letterbox nearest-neighbor scaler map.
//
// Configure source/target sizes and bytes per pixel over the cfg_* write
// port, then stream target pixel coordinates in on s_* and take one result
// per coordinate on m_*. Each result says whether the pixel lies in the
// centered, aspect-kept picture and gives the nearest source column/row plus
// source and target byte offsets; outside the picture the pixel is background.
//
// After reset and after every config write, a serial solver works out the
// drawn rectangle (one or two 26-step divisions); s_tready stays low meanwhile.
// Afterwards one transaction per cycle is accepted unless a low m_tready
// has filled every stage. Items pass P1, P2, the divider seed stage, the two
// 13-stage per-pixel dividers (x and y) and the multiply stages around them.
// When m_tready is low the result holds and the pipeline keeps filling its
// empty stages; s_tready then drops only once every stage holds an item.
// Reset empties the pipeline and restores the register defaults.
module letterbox_nearest_scaler_map #(
    parameter int MAX_DIMENSION = lnsm_pkg::MAX_DIMENSION_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lnsm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lnsm_pkg::DIM_W-1:0]         cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lnsm_pkg::IN_TDATA_W-1:0]    s_tdata,   // pixel_x, pixel_y
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // src_col, src_row, src_byte_offset, dst_byte_offset, 4 zero bits
    output logic [lnsm_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [lnsm_pkg::OUT_TUSER_W-1:0]   m_tuser    // setup_error, inside_picture
);
    import lnsm_pkg::*;

    localparam int DIV_STEPS = DIM_W;
    localparam int ST_DIV0   = 2;
    localparam int ST_PA     = ST_DIV0 + DIV_STEPS + 1;
    localparam int ST_OUT    = ST_PA + 1;
    localparam int N_ST      = ST_OUT + 1;
    localparam int PAD_W     = OUT_TDATA_W - 2 * PIX_W - 2 * OFS_W;

    typedef struct packed {
        logic             surf;
        logic             rect;
        logic [OFS_W-1:0] dpix;
        logic [DIM_W-1:0] rx;
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] qx;
        logic [DIM_W-1:0] ry;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] qy;
    } div_t;

    // configuration registers
    logic [DIM_W-1:0] sw_reg, sh_reg, tw_reg, th_reg;
    logic [BPP_W-1:0] bpp_reg;

    geom_t            geom;
    logic             geom_rdy;

    logic [N_ST-1:0]  vld_reg;
    logic [N_ST-1:0]  adv;

    // stage P1
    logic [PIX_W-1:0] px1_reg, py1_reg;
    // stage P2
    logic             surf2_reg, rect2_reg;
    logic [DIM_W-1:0] dx2_reg, dy2_reg;
    logic [PIX_W-1:0] px2_reg, py2_reg;
    // divider stages
    div_t             div_reg [DIV_STEPS+1];
    // stage PA
    logic             surf_a_reg, rect_a_reg;
    logic [DIM_W-1:0] sx_a_reg, sy_a_reg;
    logic [OFS_W-1:0] sprod_a_reg, dpix_a_reg;
    // output stage
    logic             err_o_reg, in_o_reg;
    logic [PIX_W-1:0] col_o_reg, row_o_reg;
    logic [OFS_W-1:0] soff_o_reg, doff_o_reg;

    logic [DIM_W-1:0]   px_e, py_e;
    logic [DIM_W:0]     x_end, y_end;
    logic               surf_c, rect_c;
    logic [PROD_W-1:0]  nx_full, ny_full;
    logic [OFS_W-1:0]   dpix_c;
    logic [OFS_W-1:0]   spix_c;
    logic [OFS_W+BPP_W-1:0] soff_w, doff_w;
    logic               inside_c, surf_ok_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= DIM_W'(1);
            sh_reg  <= DIM_W'(1);
            tw_reg  <= '0;
            th_reg  <= '0;
            bpp_reg <= BPP_RGB;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SRC_W: sw_reg  <= cfg_data;
                REG_SRC_H: sh_reg  <= cfg_data;
                REG_TGT_W: tw_reg  <= cfg_data;
                REG_TGT_H: th_reg  <= cfg_data;
                REG_BPP:   bpp_reg <= cfg_data[BPP_W-1:0];
                default:   ;
            endcase
        end
    end

    lnsm_geom #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_geom (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_wr_en),
        .sw      (sw_reg),
        .sh      (sh_reg),
        .tw      (tw_reg),
        .th      (th_reg),
        .bpp     (bpp_reg),
        .geom    (geom),
        .rdy     (geom_rdy)
    );

    // a stage moves when it is empty or the next one moves
    assign adv[N_ST-1] = !vld_reg[N_ST-1] || m_tready;
    for (genvar i = 0; i < N_ST - 1; i++)
    begin : g_adv
        assign adv[i] = !vld_reg[i] || adv[i+1];
    end

    assign s_tready = adv[0] && geom_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid && s_tready;
            end
            for (int i = 1; i < N_ST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // P1: capture coordinates
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            px1_reg <= s_tdata[PIX_W-1:0];
            py1_reg <= s_tdata[2*PIX_W-1:PIX_W];
        end
    end

    // P2: surface and rectangle tests, offsets into the rectangle
    assign px_e   = {1'b0, px1_reg};
    assign py_e   = {1'b0, py1_reg};
    assign x_end  = {1'b0, geom.x0} + {1'b0, geom.dw};
    assign y_end  = {1'b0, geom.y0} + {1'b0, geom.dh};
    assign surf_c = (px_e < tw_reg) && (py_e < th_reg);
    assign rect_c = (px_e >= geom.x0) && ({1'b0, px_e} < x_end)
                    && (py_e >= geom.y0) && ({1'b0, py_e} < y_end);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            surf2_reg <= surf_c;
            rect2_reg <= rect_c;
            dx2_reg   <= px_e - geom.x0;
            dy2_reg   <= py_e - geom.y0;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
        end
    end

    // dividend products; the upper half seeds the remainder
    assign nx_full = {{DIM_W{1'b0}}, dx2_reg} * {{DIM_W{1'b0}}, sw_reg};
    assign ny_full = {{DIM_W{1'b0}}, dy2_reg} * {{DIM_W{1'b0}}, sh_reg};
    assign dpix_c  = {{(OFS_W-PIX_W){1'b0}}, py2_reg} * {{(OFS_W-DIM_W){1'b0}}, tw_reg}
                     + {{(OFS_W-PIX_W){1'b0}}, px2_reg};

    always_ff @(posedge clk)
    begin
        if (adv[ST_DIV0])
        begin
            div_reg[0].surf <= surf2_reg;
            div_reg[0].rect <= rect2_reg;
            div_reg[0].dpix <= dpix_c;
            div_reg[0].rx   <= nx_full[PROD_W-1:DIM_W];
            div_reg[0].nx   <= nx_full[DIM_W-1:0];
            div_reg[0].qx   <= '0;
            div_reg[0].ry   <= ny_full[PROD_W-1:DIM_W];
            div_reg[0].ny   <= ny_full[DIM_W-1:0];
            div_reg[0].qy   <= '0;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        div_step_t stx, sty;
        div_t      div_next;

        assign stx = div_step(div_reg[k].rx, div_reg[k].nx[DIM_W-1], geom.dw);
        assign sty = div_step(div_reg[k].ry, div_reg[k].ny[DIM_W-1], geom.dh);

        always_comb
        begin
            div_next    = div_reg[k];
            div_next.rx = stx.rem;
            div_next.nx = div_reg[k].nx << 1;
            div_next.qx = {div_reg[k].qx[DIM_W-2:0], stx.qbit};
            div_next.ry = sty.rem;
            div_next.ny = div_reg[k].ny << 1;
            div_next.qy = {div_reg[k].qy[DIM_W-2:0], sty.qbit};
        end

        always_ff @(posedge clk)
        begin
            if (adv[ST_DIV0+k+1])
            begin
                div_reg[k+1] <= div_next;
            end
        end
    end

    // PA: source row product
    always_ff @(posedge clk)
    begin
        if (adv[ST_PA])
        begin
            surf_a_reg  <= div_reg[DIV_STEPS].surf;
            rect_a_reg  <= div_reg[DIV_STEPS].rect;
            sx_a_reg    <= div_reg[DIV_STEPS].qx;
            sy_a_reg    <= div_reg[DIV_STEPS].qy;
            sprod_a_reg <= {{DIM_W{1'b0}}, div_reg[DIV_STEPS].qy}
                           * {{DIM_W{1'b0}}, sw_reg};
            dpix_a_reg  <= div_reg[DIV_STEPS].dpix;
        end
    end

    // output stage: scale by channel count, mask per case
    assign spix_c    = sprod_a_reg + {{(OFS_W-DIM_W){1'b0}}, sx_a_reg};
    assign soff_w    = {{BPP_W{1'b0}}, spix_c} * {{OFS_W{1'b0}}, bpp_reg};
    assign doff_w    = {{BPP_W{1'b0}}, dpix_a_reg} * {{OFS_W{1'b0}}, bpp_reg};
    assign surf_ok_c = !geom.err && surf_a_reg;
    assign inside_c  = surf_ok_c && rect_a_reg;

    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            err_o_reg  <= geom.err;
            in_o_reg   <= inside_c;
            col_o_reg  <= inside_c ? sx_a_reg[PIX_W-1:0] : '0;
            row_o_reg  <= inside_c ? sy_a_reg[PIX_W-1:0] : '0;
            soff_o_reg <= inside_c ? soff_w[OFS_W-1:0] : '0;
            doff_o_reg <= surf_ok_c ? doff_w[OFS_W-1:0] : '0;
        end
    end

    assign m_tvalid = vld_reg[ST_OUT];
    assign m_tdata  = {{PAD_W{1'b0}}, doff_o_reg, soff_o_reg, row_o_reg, col_o_reg};
    assign m_tuser  = {in_o_reg, err_o_reg};

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tuser[1])
        else $error("setup error result carries nonzero fields");

    a_bg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[2*PIX_W+OFS_W-1:0] == '0))
        else $error("background result carries source fields");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> ({1'b0, col_o_reg} < sw_reg))
        else $error("source column beyond source width");

    a_setup_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !geom_rdy |-> !s_tready)
        else $error("input accepted while geometry is being solved");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> !geom_rdy)
        else $error("geometry not re-solved after a config write");
`endif

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import lnsm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_TAIL = 40;

    typedef struct packed {
        logic             setup_error;
        logic             inside_picture;
        logic [PIX_W-1:0] src_col;
        logic [PIX_W-1:0] src_row;
        logic [OFS_W-1:0] src_ofs;
        logic [OFS_W-1:0] dst_ofs;
    } pixel_map_t;

    class pixel_map_tracker;
        longint unsigned src_w;
        longint unsigned src_h;
        longint unsigned tgt_w;
        longint unsigned tgt_h;
        longint unsigned bpp;
        pixel_map_t      pending_maps[$];
        int              errors;

        function new();
            src_w  = 1;
            src_h  = 1;
            tgt_w  = 0;
            tgt_h  = 0;
            bpp    = BPP_RGB;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
            case (idx)
                REG_SRC_W: src_w = value;
                REG_SRC_H: src_h = value;
                REG_TGT_W: tgt_w = value;
                REG_TGT_H: tgt_h = value;
                REG_BPP:   bpp = value[BPP_W-1:0];
                default: ;
            endcase
        endfunction

        function bit dim_ok(longint unsigned d);
            return d != 0 && d <= MAX_DIMENSION_DEF;
        endfunction

        function pixel_map_t map_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            pixel_map_t      r;
            longint unsigned x, y, dw, dh, x0, y0, sx, sy;
            r = '0;
            x = px;
            y = py;
            if (!dim_ok(tgt_w) || !dim_ok(tgt_h) || !dim_ok(src_w) || !dim_ok(src_h) ||
                (bpp != BPP_RGB && bpp != BPP_RGBA))
            begin
                r.setup_error = 1'b1;
                return r;
            end
            // fit by width first, fall back to height when too tall
            dw = tgt_w;
            dh = dw * src_h / src_w;
            if (dh > tgt_h)
            begin
                dh = tgt_h;
                dw = dh * src_w / src_h;
            end
            if (dw == 0 || dh == 0)
            begin
                r.setup_error = 1'b1;
                return r;
            end
            if (x >= tgt_w || y >= tgt_h)
                return r;
            r.dst_ofs = OFS_W'((y * tgt_w + x) * bpp);
            x0 = (tgt_w - dw) / 2;
            y0 = (tgt_h - dh) / 2;
            if (x < x0 || x >= x0 + dw || y < y0 || y >= y0 + dh)
                return r;
            sx = (x - x0) * src_w / dw;
            sy = (y - y0) * src_h / dh;
            r.inside_picture = 1'b1;
            r.src_col = PIX_W'(sx);
            r.src_row = PIX_W'(sy);
            r.src_ofs = OFS_W'((sy * src_w + sx) * bpp);
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
            pending_maps.push_back(map_pixel(px, py));
        endfunction

        function int pending();
            return pending_maps.size();
        endfunction

        function void check_mapping(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
            pixel_map_t got;
            pixel_map_t want;
            got.setup_error    = user[0];
            got.inside_picture = user[1];
            got.src_col        = data[PIX_W-1:0];
            got.src_row        = data[2*PIX_W-1:PIX_W];
            got.src_ofs        = data[2*PIX_W+OFS_W-1:2*PIX_W];
            got.dst_ofs        = data[2*PIX_W+2*OFS_W-1:2*PIX_W+OFS_W];
            if (pending_maps.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: tuser=%h tdata=%h", user, data);
                return;
            end
            want = pending_maps.pop_front();
            if (got != want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: expected err=%0d in=%0d col=%0d row=%0d src=%0d dst=%0d",
                             want.setup_error, want.inside_picture, want.src_col,
                             want.src_row, want.src_ofs, want.dst_ofs);
                    $display("          actual   err=%0d in=%0d col=%0d row=%0d src=%0d dst=%0d",
                             got.setup_error, got.inside_picture, got.src_col,
                             got.src_row, got.src_ofs, got.dst_ofs);
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DIM_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    pixel_map_tracker tracker = new();
    bit               steady = 1'b0;
    int               cycles = 0;

    letterbox_nearest_scaler_map uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: check, then decide on a stall for the next cycle
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tracker.check_mapping(m_tdata, m_tuser);
            m_tready <= steady || ($urandom_range(99) >= 10);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        while (!steady && $urandom_range(99) < 10)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_pixel(px, py);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic setup(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                         input logic [DIM_W-1:0] tw, input logic [DIM_W-1:0] th,
                         input logic [DIM_W-1:0] bpp);
        logic [CFG_IDX_W-1:0] regs[5];
        logic [DIM_W-1:0]     vals[5];
        regs = '{REG_SRC_W, REG_SRC_H, REG_TGT_W, REG_TGT_H, REG_BPP};
        vals = '{sw, sh, tw, th, bpp};
        for (int i = 0; i < 5; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            tracker.set_register(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DIM_W-1:0] rand_dim();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: return DIM_W'($urandom_range(1, 64));
            6, 7:             return DIM_W'($urandom_range(1, MAX_DIMENSION_DEF));
            8:                return $urandom_range(1) ? DIM_W'(MAX_DIMENSION_DEF) : DIM_W'(1);
            default:          return DIM_W'($urandom_range(1, 512));
        endcase
    endfunction

    // mostly on the surface, sometimes anywhere in the 12-bit range
    function automatic logic [PIX_W-1:0] pick_coord(longint unsigned span);
        if (span == 0 || span > MAX_DIMENSION_DEF || $urandom_range(99) < 15)
            return PIX_W'($urandom);
        return PIX_W'($urandom_range(32'(span) - 1));
    endfunction

    task automatic random_setup();
        logic [DIM_W-1:0] v[5];
        logic [BPP_W-1:0] bad_bpp[6];
        int               k;
        bad_bpp = '{3'd0, 3'd1, 3'd2, 3'd5, 3'd6, 3'd7};
        for (int i = 0; i < 4; i++)
            v[i] = rand_dim();
        v[4] = $urandom_range(1) ? DIM_W'(BPP_RGBA) : DIM_W'(BPP_RGB);
        // now and then break one register
        if ($urandom_range(7) == 0)
        begin
            k = $urandom_range(4);
            if (k == 4)
                v[4] = DIM_W'(bad_bpp[$urandom_range(5)]);
            else
                v[k] = $urandom_range(1) ? DIM_W'(0) : DIM_W'($urandom_range(4097, 8191));
        end
        setup(v[0], v[1], v[2], v[3], v[4]);
    endtask

    initial
    begin
        logic [BPP_W-1:0] odd_bpp[3];
        odd_bpp = '{3'd0, 3'd7, 3'd5};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults: zero target size
        send_pixel(12'd5, 12'd5);
        drain();

        // wide source, fit by width, bars top and bottom
        setup(13'd4, 13'd3, 13'd8, 13'd8, DIM_W'(BPP_RGB));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd7, 12'd6);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd7, 12'd7);
        send_pixel(12'd8, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // tall source on the largest target, fit by height
        setup(13'd2, 13'd5, 13'd4096, 13'd4096, DIM_W'(BPP_RGBA));
        send_pixel(12'd1229, 12'd0);
        send_pixel(12'd2866, 12'd4095);
        send_pixel(12'd1228, 12'd100);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'haaa, 12'h555);
        send_pixel(12'h555, 12'haaa);
        drain();

        // drawn height floors to zero
        setup(13'd4096, 13'd1, 13'd1, 13'd1, DIM_W'(BPP_RGB));
        send_pixel(12'd0, 12'd0);
        drain();

        // target too large
        setup(13'd1, 13'd1, 13'd4097, 13'd16, DIM_W'(BPP_RGB));
        send_pixel(12'd0, 12'd0);
        drain();
        setup(13'd1, 13'd1, 13'd16, 13'd8191, DIM_W'(BPP_RGB));
        send_pixel(12'd1, 12'd1);
        drain();

        // bad source sizes
        setup(13'd0, 13'd1, 13'd16, 13'd16, DIM_W'(BPP_RGB));
        send_pixel(12'd2, 12'd2);
        drain();
        setup(13'd16, 13'd8191, 13'd16, 13'd16, DIM_W'(BPP_RGBA));
        send_pixel(12'd3, 12'd3);
        drain();

        // unsupported channel counts
        foreach (odd_bpp[i])
        begin
            setup(13'd16, 13'd16, 13'd16, 13'd16, DIM_W'(odd_bpp[i]));
            send_pixel(12'd4, 12'd4);
            drain();
        end

        for (int ph = 0; ph < 15; ph++)
        begin
            steady = (ph == 4 || ph == 5);
            random_setup();
            for (int n = 0; n < 50; n++)
            begin
                if (ph == 8 && n == 25)
                    drain();
                send_pixel(pick_coord(tracker.tgt_w), pick_coord(tracker.tgt_h));
            end
            drain();
        end

        repeat (DRAIN_TAIL) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
